>>> hw/rtl/llsf_pkg.sv
// shared types, constants and status codes for the line fit core
`timescale 1ns / 1ps
package llsf_pkg;

    localparam int MaxPoints = 4096;
    localparam int CountW = 13;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SINGULAR = 2'd1;
    localparam logic [1:0] ST_NOT_FIT  = 2'd2;
    localparam logic [1:0] ST_TOO_MANY = 2'd3;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic KIND_FIT  = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] slope;
        logic signed [31:0] intercept;
        logic signed [15:0] y_value;
        logic [1:0]         status;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic accum;      // add the held point to the sums
        logic prod_load;  // start product phase
        logic prod_step;  // one product step
        logic div_start;  // load a divide (0 slope, 1 intercept)
        logic div_sel;
        logic div_step;
        logic div_store;  // store quotient
        logic fit_commit; // finish fit, clear sums
        logic eval_mul;
        logic eval_fin;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic prod_done;
        logic div_done;
        logic fit_ok;
    } dp_stat_t;

endpackage

>>> hw/rtl/llsf_datapath.sv
// sums, product sequencer, restoring divider and evaluation path
`timescale 1ns / 1ps
module llsf_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  llsf_pkg::in_item_t  item,
    input  llsf_pkg::dp_cmd_t   cmd,
    output llsf_pkg::dp_stat_t  stat,
    output llsf_pkg::out_item_t result
);

    logic signed [27:0]          sx_reg, sy_reg;
    logic [42:0]                 sxx_reg;
    logic signed [43:0]          sxy_reg;
    logic [llsf_pkg::CountW-1:0] cnt_reg;
    logic                        ovf_reg;
    logic signed [31:0]          fm_reg, fb_reg;
    logic                        fv_reg;

    // product phase registers
    logic [2:0]          pstep_reg;
    logic signed [127:0] d_reg, nm_reg, nb_reg;
    logic signed [127:0] acc_reg;
    logic signed [63:0]  pa, pb;

    // 64x64 signed product: operand load, then four 32x32 partial products
    logic [2:0]          part_reg;
    logic [63:0]         ma_reg, mb_reg;
    logic                mneg_reg;
    logic [127:0]        macc_reg;
    logic [63:0]         pp;
    logic signed [127:0] fin_prod;
    logic [127:0]        fin_mag;

    always_comb
    begin
        pa = '0;
        pb = '0;
        case (pstep_reg)
            3'd0: begin pa = 64'(cnt_reg);     pb = 64'(sxx_reg); end
            3'd1: begin pa = 64'(sx_reg);      pb = 64'(sx_reg);  end
            3'd2: begin pa = 64'(cnt_reg);     pb = 64'(sxy_reg); end
            3'd3: begin pa = 64'(sx_reg);      pb = 64'(sy_reg);  end
            3'd4: begin pa = 64'(sy_reg);      pb = 64'(sxx_reg); end
            3'd5: begin pa = 64'(sx_reg);      pb = 64'(sxy_reg); end
            default: begin pa = '0; pb = '0; end
        endcase
    end

    always_comb
    begin
        case (part_reg)
            3'd1: pp = ma_reg[31:0]  * mb_reg[31:0];
            3'd2: pp = ma_reg[31:0]  * mb_reg[63:32];
            3'd3: pp = ma_reg[63:32] * mb_reg[31:0];
            default: pp = ma_reg[63:32] * mb_reg[63:32];
        endcase
    end

    // full product once the high partial product lands
    assign fin_mag  = macc_reg + (128'(pp) << 64);
    assign fin_prod = mneg_reg ? -$signed(fin_mag) : $signed(fin_mag);

    // divider
    logic [127:0] dn_reg, dd_reg, dr_reg, dq_reg;
    logic [7:0]   dcnt_reg;
    logic         dneg_reg, dbusy_reg;
    logic         dstep;
    logic [127:0] rsh, rsub;
    logic [127:0] numag, nshift;

    assign rsh   = {dr_reg[126:0], dn_reg[127]};
    assign rsub  = rsh - dd_reg;
    assign dstep = cmd.div_step && dbusy_reg && (dcnt_reg != 8'd0);

    always_comb
    begin
        numag  = cmd.div_sel ? (nb_reg[127] ? 128'(-nb_reg) : 128'(nb_reg))
                             : (nm_reg[127] ? 128'(-nm_reg) : 128'(nm_reg));
        nshift = cmd.div_sel ? {numag[118:0], 9'd0} : {numag[110:0], 17'd0};
    end

    logic signed [31:0] qsat;
    always_comb
    begin
        if (dneg_reg)
            qsat = (dq_reg[127:31] != '0) ? 32'sh8000_0000 : -$signed(dq_reg[31:0]);
        else
            qsat = (dq_reg[127:31] != '0) ? 32'sh7fff_ffff : $signed(dq_reg[31:0]);
    end

    logic signed [63:0] es_reg;
    logic [63:0]        emag, em;
    always_comb
    begin
        emag = es_reg[63] ? 64'(-es_reg) : 64'(es_reg);
        em   = (emag + 64'h8000) >> 16;
    end

    logic pdone;
    assign pdone = (pstep_reg == 3'd5) && (part_reg == 3'd4);
    assign stat.prod_done = pdone;
    assign stat.div_done  = (dcnt_reg == 8'd0) && dbusy_reg;
    assign stat.fit_ok    = !ovf_reg && !d_reg[127] && (d_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg <= '0; sy_reg <= '0; sxx_reg <= '0; sxy_reg <= '0;
            cnt_reg <= '0; ovf_reg <= 1'b0;
            fm_reg <= '0; fb_reg <= '0; fv_reg <= 1'b0;
            pstep_reg <= '0; part_reg <= '0; dcnt_reg <= '0; dbusy_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accum)
            begin
                if (32'(cnt_reg) < llsf_pkg::MaxPoints)
                begin
                    sx_reg  <= sx_reg + 28'(item.x);
                    sy_reg  <= sy_reg + 28'(item.y);
                    sxx_reg <= sxx_reg + 43'(item.x * item.x);
                    sxy_reg <= sxy_reg + 44'(item.x * item.y);
                    cnt_reg <= cnt_reg + llsf_pkg::CountW'(1);
                end
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.prod_load)
            begin
                pstep_reg <= '0;
                part_reg  <= '0;
            end
            else if (cmd.prod_step)
            begin
                if (part_reg == 3'd4)
                begin
                    part_reg <= '0;
                    if (!pdone)
                        pstep_reg <= pstep_reg + 3'd1;
                end
                else
                    part_reg <= part_reg + 3'd1;
            end
            if (cmd.div_start)
            begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= 8'd128;
            end
            else if (dstep)
                dcnt_reg <= dcnt_reg - 8'd1;
            if (cmd.div_store)
            begin
                dbusy_reg <= 1'b0;
                if (cmd.div_sel) fb_reg <= qsat; else fm_reg <= qsat;
            end
            if (cmd.fit_commit)
            begin
                if (!stat.fit_ok)
                begin
                    fm_reg <= '0; fb_reg <= '0;
                end
                fv_reg <= stat.fit_ok;
                sx_reg <= '0; sy_reg <= '0; sxx_reg <= '0; sxy_reg <= '0;
                cnt_reg <= '0; ovf_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.prod_step)
        begin
            case (part_reg)
                3'd0:
                begin
                    ma_reg   <= pa[63] ? 64'(-pa) : 64'(pa);
                    mb_reg   <= pb[63] ? 64'(-pb) : 64'(pb);
                    mneg_reg <= pa[63] ^ pb[63];
                    macc_reg <= '0;
                end
                3'd1: macc_reg <= macc_reg + 128'(pp);
                3'd2, 3'd3: macc_reg <= macc_reg + (128'(pp) << 32);
                default:
                begin
                    case (pstep_reg)
                        3'd0: acc_reg <= fin_prod;
                        3'd1: d_reg   <= acc_reg - fin_prod;
                        3'd2: acc_reg <= fin_prod;
                        3'd3: nm_reg  <= acc_reg - fin_prod;
                        3'd4: acc_reg <= fin_prod;
                        3'd5: nb_reg  <= acc_reg - fin_prod;
                        default: ;
                    endcase
                end
            endcase
        end
        if (cmd.div_start)
        begin
            // round half away: (2*mag + d) / (2*d), nshift already holds 2*mag
            dn_reg   <= nshift + 128'(d_reg);
            dd_reg   <= {d_reg[126:0], 1'b0};
            dr_reg   <= '0;
            dq_reg   <= '0;
            dneg_reg <= cmd.div_sel ? nb_reg[127] : nm_reg[127];
        end
        else if (dstep)
        begin
            dn_reg <= {dn_reg[126:0], 1'b0};
            if (rsh >= dd_reg)
            begin
                dr_reg <= rsub;
                dq_reg <= {dq_reg[126:0], 1'b1};
            end
            else
            begin
                dr_reg <= rsh;
                dq_reg <= {dq_reg[126:0], 1'b0};
            end
        end
        if (cmd.eval_mul)
            es_reg <= 64'(fm_reg * item.x) + (64'(fb_reg) <<< 8);
        if (cmd.eval_fin)
        begin
            result.kind      <= llsf_pkg::KIND_EVAL;
            result.slope     <= '0;
            result.intercept <= '0;
            if (!fv_reg)
            begin
                result.y_value <= '0;
                result.status  <= llsf_pkg::ST_NOT_FIT;
            end
            else
            begin
                result.status <= llsf_pkg::ST_OK;
                if (es_reg[63])
                    result.y_value <= (em > 64'd32768) ? 16'sh8000 : 16'(-em);
                else
                    result.y_value <= (em > 64'd32767) ? 16'sh7fff : 16'(em);
            end
        end
        if (cmd.fit_commit)
        begin
            result.kind      <= llsf_pkg::KIND_FIT;
            result.y_value   <= '0;
            result.slope     <= stat.fit_ok ? fm_reg : '0;
            result.intercept <= stat.fit_ok ? fb_reg : '0;
            result.status    <= ovf_reg ? llsf_pkg::ST_TOO_MANY
                              : (stat.fit_ok ? llsf_pkg::ST_OK : llsf_pkg::ST_SINGULAR);
        end
    end

endmodule

>>> hw/rtl/llsf_ctrl.sv
// sequencer for accumulate, solve and evaluate
`timescale 1ns / 1ps
module llsf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_command,
    input  logic               in_last,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output llsf_pkg::dp_cmd_t  cmd,
    input  llsf_pkg::dp_stat_t stat
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PROD   = 3'd1;
    localparam logic [2:0] S_DIVM   = 3'd2;
    localparam logic [2:0] S_DIVB   = 3'd3;
    localparam logic [2:0] S_EVAL   = 3'd4;
    localparam logic [2:0] S_DIVM0  = 3'd5;
    localparam logic [2:0] S_DIVB0  = 3'd6;
    localparam logic [2:0] S_COMMIT = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       take;

    assign in_stall  = (state_reg != S_IDLE) || (ov_reg && out_stall);
    assign out_valid = ov_reg;
    assign take      = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (in_command == llsf_pkg::CMD_EVAL)
                    begin
                        cmd.eval_mul = 1'b1;
                        state_next   = S_EVAL;
                    end
                    else
                    begin
                        cmd.accum = 1'b1;
                        if (in_last)
                        begin
                            cmd.prod_load = 1'b1;
                            state_next    = S_PROD;
                        end
                    end
                end
            end
            S_EVAL:
            begin
                cmd.eval_fin = 1'b1;
                ov_next      = 1'b1;
                state_next   = S_IDLE;
            end
            S_PROD:
            begin
                cmd.prod_step = 1'b1;
                if (stat.prod_done)
                    state_next = S_DIVM0;
            end
            S_DIVM0:
            begin
                if (stat.fit_ok)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVM;
                end
                else
                begin
                    cmd.fit_commit = 1'b1;
                    ov_next        = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DIVM:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = S_DIVB0;
                end
            end
            S_DIVB0:
            begin
                cmd.div_sel   = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_DIVB;
            end
            S_DIVB:
            begin
                cmd.div_sel  = 1'b1;
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.fit_commit = 1'b1;
                ov_next        = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

>>> hw/rtl/linear_least_squares_fit_core.sv
// top level of the least squares line fit core
// Usage: requests enter on in_valid/in_stall with an in_item_t payload and
// results leave on out_valid/out_stall with an out_item_t payload.
// A point request without last is absorbed and gives no result; such requests
// can follow back to back while no result waits on a stalled receiver.
// A point request with last adds the point, then solves the fit: six 64x64
// products built from 32x32 partial products, then two 128-step restoring
// divides on the shared divider, slope and then intercept, and a commit.
// A singular or too-many-points set skips the divides and its result is
// committed right after the products.
// An evaluate request registers m*x + b first, then the result.
// One request is worked on at a time; the core stalls input while busy.
// The result sits in an output register until the receiver takes it;
// while out_stall holds, the payload stays and no new request is taken
// if a result is still waiting.
// Reset clears the sums, the point count and the fitted line.
`timescale 1ns / 1ps
module linear_least_squares_fit_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  llsf_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output llsf_pkg::out_item_t out_data
);

    llsf_pkg::dp_cmd_t  cmd;
    llsf_pkg::dp_stat_t stat;

    llsf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (in_data.command),
        .in_last    (in_data.last),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cmd        (cmd),
        .stat       (stat)
    );

    llsf_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_data),
        .cmd    (cmd),
        .stat   (stat),
        .result (out_data)
    );

endmodule

>>> tb/sv/linear_least_squares_fit_core_tb.sv
// testbench for the least squares line fit core: directed table, random point sets, scoreboard
`timescale 1ns / 1ps
module linear_least_squares_fit_core_tb;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    llsf_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_stall;
    llsf_pkg::out_item_t out_data;

    linear_least_squares_fit_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    // predictor state
    longint        acc_x, acc_y, acc_xx, acc_xy;
    int            n_points;
    bit            too_many;
    logic [31:0]   line_m, line_b;
    bit            line_ok;

    llsf_pkg::out_item_t expected_q[$];
    int            errors = 0;
    int            fits_seen = 0, evals_seen = 0;
    bit            hold_long = 0;

    // round(num * 2^sh / d), ties away from zero, saturated to 32 bits; d > 0
    function automatic logic [31:0] round_quot(logic signed [127:0] num, int sh,
                                               logic [127:0] d);
        logic [127:0] mag;
        logic [127:0] q;
        bit neg;
        neg = num < 0;
        mag = neg ? -num : num;
        mag = mag << sh;
        q = ((mag << 1) + d) / (d << 1);
        if (neg) return (q >= 128'h8000_0000) ? 32'h8000_0000 : -q[31:0];
        return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    function automatic llsf_pkg::out_item_t predict_line(llsf_pkg::in_item_t req,
                                                         output bit has_res);
        llsf_pkg::out_item_t r;
        logic signed [127:0] d, nm, nb, n;
        logic signed [63:0] s;
        logic [63:0] mag;
        has_res = 0;
        r = '0;
        if (req.command == llsf_pkg::CMD_ADD) begin
            if (n_points < llsf_pkg::MaxPoints) begin
                acc_x += req.x;
                acc_y += req.y;
                acc_xx += longint'(req.x) * req.x;
                acc_xy += longint'(req.x) * req.y;
                n_points++;
            end
            else
                too_many = 1;
            if (!req.last) return r;
            has_res = 1;
            r.kind = llsf_pkg::KIND_FIT;
            n = n_points;
            d = n * acc_xx - 128'(signed'(acc_x)) * acc_x;
            if (too_many) r.status = llsf_pkg::ST_TOO_MANY;
            else if (d <= 0) r.status = llsf_pkg::ST_SINGULAR;
            else r.status = llsf_pkg::ST_OK;
            if (r.status == llsf_pkg::ST_OK) begin
                nm = n * acc_xy - 128'(signed'(acc_x)) * acc_y;
                nb = 128'(signed'(acc_y)) * acc_xx - 128'(signed'(acc_x)) * acc_xy;
                line_m = round_quot(nm, 16, d);
                line_b = round_quot(nb, 8, d);
                line_ok = 1;
            end
            else begin
                line_m = 0;
                line_b = 0;
                line_ok = 0;
            end
            r.slope = line_m;
            r.intercept = line_b;
            acc_x = 0; acc_y = 0; acc_xx = 0; acc_xy = 0;
            n_points = 0;
            too_many = 0;
            return r;
        end
        has_res = 1;
        r.kind = llsf_pkg::KIND_EVAL;
        if (!line_ok) begin
            r.status = llsf_pkg::ST_NOT_FIT;
            return r;
        end
        s = longint'(signed'(line_m)) * req.x + longint'(signed'(line_b)) * 256;
        mag = ((s < 0 ? -s : s) + 64'h8000) >> 16;
        if (s < 0) r.y_value = (mag > 32768) ? 16'sh8000 : -mag[15:0];
        else r.y_value = (mag > 32767) ? 16'sh7FFF : mag[15:0];
        r.status = llsf_pkg::ST_OK;
        return r;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // send one request; gap drawn before it, valid stays up when there is none
    task automatic send_req(llsf_pkg::in_item_t req);
        llsf_pkg::out_item_t r;
        bit has;
        int gap;
        gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        in_data <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        r = predict_line(req, has);
        if (has) expected_q.push_back(r);
        @(negedge clk);
    endtask

    // directed request plus an optional typed-in expectation
    task automatic send_known(llsf_pkg::in_item_t req, bit chk, llsf_pkg::out_item_t want);
        send_req(req);
        if (chk && (expected_q.size() == 0 || expected_q[$] !== want)) begin
            $error("directed row: expected %h, predictor %h", want,
                   expected_q.size() != 0 ? expected_q[$] : '0);
            errors++;
        end
    endtask

    function automatic llsf_pkg::in_item_t mk(logic cmd, logic [15:0] x, logic [15:0] y,
                                              logic l);
        llsf_pkg::in_item_t t;
        t.command = cmd; t.x = x; t.y = y; t.last = l;
        return t;
    endfunction

    function automatic llsf_pkg::out_item_t mo(logic k, logic [31:0] m, logic [31:0] b,
                                               logic [15:0] v, logic [1:0] st);
        llsf_pkg::out_item_t t;
        t.kind = k; t.slope = m; t.intercept = b; t.y_value = v; t.status = st;
        return t;
    endfunction

    task automatic drain();
        in_valid <= 0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // random point set, mostly well formed
    task automatic random_set(int npts, int span);
        int k;
        for (k = 0; k < npts; k++)
            send_req(mk(llsf_pkg::CMD_ADD, $urandom_range(0, 3) == 0 ? 16'($urandom) :
                        16'($urandom_range(0, 2 * span) - span),
                        16'($urandom), k == npts - 1));
    endtask

    llsf_pkg::in_item_t  dir_req[$];
    bit                  dir_chk[$];
    llsf_pkg::out_item_t dir_want[$];

    task automatic add_row(llsf_pkg::in_item_t req, bit chk, llsf_pkg::out_item_t want);
        dir_req.push_back(req); dir_chk.push_back(chk); dir_want.push_back(want);
    endtask

    initial
    begin
        int i, n;
        in_valid = 0;
        in_data = '0;
        rst_n = 0;
        acc_x = 0; acc_y = 0; acc_xx = 0; acc_xy = 0;
        n_points = 0; too_many = 0; line_m = 0; line_b = 0; line_ok = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // evaluate before any fit, single point, equal x, extremes
        add_row(mk(llsf_pkg::CMD_EVAL, 16'h1234, 16'h0, 0), 1,
                mo(llsf_pkg::KIND_EVAL, 0, 0, 0, llsf_pkg::ST_NOT_FIT));
        add_row(mk(llsf_pkg::CMD_ADD, 16'h0100, 16'h0200, 1), 1,
                mo(llsf_pkg::KIND_FIT, 0, 0, 0, llsf_pkg::ST_SINGULAR));
        add_row(mk(llsf_pkg::CMD_ADD, 16'h0300, 16'h0100, 0), 0, '0);
        add_row(mk(llsf_pkg::CMD_ADD, 16'h0300, 16'h7FFF, 1), 1,
                mo(llsf_pkg::KIND_FIT, 0, 0, 0, llsf_pkg::ST_SINGULAR));
        add_row(mk(llsf_pkg::CMD_EVAL, 16'h8000, 16'hFFFF, 1), 1,
                mo(llsf_pkg::KIND_EVAL, 0, 0, 0, llsf_pkg::ST_NOT_FIT));
        // y = x through two points
        add_row(mk(llsf_pkg::CMD_ADD, 16'h0000, 16'h0000, 0), 0, '0);
        add_row(mk(llsf_pkg::CMD_ADD, 16'h0100, 16'h0100, 1), 1,
                mo(llsf_pkg::KIND_FIT, 32'h0001_0000, 0, 0, llsf_pkg::ST_OK));
        add_row(mk(llsf_pkg::CMD_EVAL, 16'h0200, 16'h0, 0), 1,
                mo(llsf_pkg::KIND_EVAL, 0, 0, 16'h0200, llsf_pkg::ST_OK));
        add_row(mk(llsf_pkg::CMD_EVAL, 16'h7FFF, 16'h0, 0), 0, '0);
        add_row(mk(llsf_pkg::CMD_EVAL, 16'h8000, 16'h0, 0), 0, '0);
        // extreme points, steep slope saturates evaluation
        add_row(mk(llsf_pkg::CMD_ADD, 16'h8000, 16'h8000, 0), 0, '0);
        add_row(mk(llsf_pkg::CMD_ADD, 16'h7FFF, 16'h7FFF, 0), 0, '0);
        add_row(mk(llsf_pkg::CMD_ADD, 16'h0000, 16'h8000, 1), 0, '0);
        add_row(mk(llsf_pkg::CMD_ADD, 16'h0000, 16'h8000, 0), 0, '0);
        add_row(mk(llsf_pkg::CMD_ADD, 16'h0001, 16'h7FFF, 1), 0, '0);
        add_row(mk(llsf_pkg::CMD_EVAL, 16'h7FFF, 16'h0, 0), 0, '0);
        add_row(mk(llsf_pkg::CMD_EVAL, 16'h8000, 16'h0, 0), 0, '0);
        add_row(mk(llsf_pkg::CMD_EVAL, 16'hFFFF, 16'h0, 1), 0, '0);
        for (i = 0; i < dir_req.size(); i++)
            send_known(dir_req[i], dir_chk[i], dir_want[i]);

        // back-pressure: receiver holds while sender keeps offering
        drain();
        hold_long = 1;
        random_set(3, 400);
        send_req(mk(llsf_pkg::CMD_EVAL, 16'($urandom), 0, 0));
        send_req(mk(llsf_pkg::CMD_EVAL, 16'($urandom), 0, 0));
        hold_long = 0;
        drain();

        n = 0;
        while (n < 625) begin
            case ($urandom_range(0, 9))
                0: begin send_req(mk(llsf_pkg::CMD_EVAL, 16'($urandom), 16'($urandom),
                                     1'($urandom))); n++; end
                1: begin send_req(mk(llsf_pkg::CMD_ADD, 16'($urandom), 16'($urandom), 1));
                    n++; end
                2, 3: begin
                    i = $urandom_range(2, 4);
                    random_set(i, 64); n += i;
                end
                default: begin
                    i = $urandom_range(2, 10);
                    random_set(i, $urandom_range(0, 1) ? 2048 : 32767); n += i;
                    repeat ($urandom_range(1, 4)) begin
                        send_req(mk(llsf_pkg::CMD_EVAL, 16'($urandom), 16'($urandom),
                                    1'($urandom)));
                        n++;
                    end
                end
            endcase
            if ($urandom_range(0, 40) == 0) drain();
        end

        drain();
        repeat (400) @(negedge clk);
        $display("covered %0d fit results and %0d evaluations, incl. singular sets and a long",
                 fits_seen, evals_seen);
        $display("receiver hold-off with the input stalled");
        if (errors == 0 && expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // receiver stall: random per result, or a long hold-off on request
    initial
    begin
        int w;
        out_stall = 0;
        forever begin
            @(negedge clk);
            if (hold_long) begin
                out_stall <= 1;
                repeat (800) @(negedge clk);
                out_stall <= 0;
                while (hold_long) @(negedge clk);
            end
            else begin
                w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 4);
                if (w != 0) begin
                    out_stall <= 1;
                    repeat (w) @(negedge clk);
                end
                out_stall <= 0;
                @(posedge clk);
                while (!(out_valid && !out_stall)) @(posedge clk);
            end
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        llsf_pkg::out_item_t w;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result %h", out_data);
                errors++;
            end
            else begin
                w = expected_q.pop_front();
                if (w.kind == llsf_pkg::KIND_FIT) fits_seen++; else evals_seen++;
                if (out_data.kind !== w.kind) begin
                    $error("kind: expected %0d got %0d", w.kind, out_data.kind); errors++;
                end
                if (out_data.slope !== w.slope) begin
                    $error("slope: expected %h got %h", w.slope, out_data.slope); errors++;
                end
                if (out_data.intercept !== w.intercept) begin
                    $error("intercept: expected %h got %h", w.intercept, out_data.intercept);
                    errors++;
                end
                if (out_data.y_value !== w.y_value) begin
                    $error("y_value: expected %h got %h", w.y_value, out_data.y_value);
                    errors++;
                end
                if (out_data.status !== w.status) begin
                    $error("status: expected %0d got %0d", w.status, out_data.status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end
endmodule

>>> files.f
hw/rtl/llsf_pkg.sv
hw/rtl/llsf_datapath.sv
hw/rtl/llsf_ctrl.sv
hw/rtl/linear_least_squares_fit_core.sv
tb/sv/linear_least_squares_fit_core_tb.sv
